/* rtl/cfbs_pkg.sv */
// Shared constants for the conflict-free batch scheduler.
package cfbs_pkg;

	// Fixed widths of the request and result fields.
	localparam int MASK_W  = 16;
	localparam int OWNER_W = 3;
	localparam int INDEX_W = 4;

	// The predecessor matrix holds one row of eight bits per owner.
	localparam int PRED_ROW_W = 8;
	localparam int PRED_W     = PRED_ROW_W * PRED_ROW_W;

endpackage

/* rtl/cfbs_ram.sv */
// Generic single-port-write, registered-read RAM.
module cfbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/conflict_free_batch_scheduler_top.sv */
// Conflict-free first-fit batch scheduler: sequencer, owner records and batch union store.
// A request passes through the predecessor pass, the scan of open batches from the earliest allowed one and
// S_WRITE, which registers the result; at most MAX_BATCHES batches are examined;
// an owner id at or above NUM_OWNERS skips the predecessor pass. A stalled result waits in S_WRITE.
// Throughput: one request at a time, the next taken in the cycle after the result is registered.
// Reset clears the matrix, batch count and owner records; union words are read only below the count.
module conflict_free_batch_scheduler_top #(
	parameter int NUM_OWNERS    = 8,
	parameter int RESOURCE_BITS = 16,
	parameter int MAX_BATCHES   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cfbs_pkg::PRED_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        first_of_tick,
	input  logic [cfbs_pkg::OWNER_W-1:0] owner_id,
	input  logic [cfbs_pkg::MASK_W-1:0] job_read_mask,
	input  logic [cfbs_pkg::MASK_W-1:0] job_write_mask,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cfbs_pkg::INDEX_W-1:0] batch_index,
	output logic                        opened_batch,
	output logic                        overflow
);

	localparam int RW = (RESOURCE_BITS < cfbs_pkg::MASK_W) ? RESOURCE_BITS : cfbs_pkg::MASK_W;
	localparam int AW = $clog2(MAX_BATCHES);
	localparam int BW = $clog2(MAX_BATCHES + 1);
	localparam int OW = $clog2(NUM_OWNERS);

	typedef enum logic [1:0] {S_IDLE, S_PRED, S_SCAN, S_WRITE} state_t;

	state_t                      state_q;
	logic [cfbs_pkg::PRED_W-1:0] pred_q;
	logic [BW-1:0]               used_q;
	logic [BW-1:0]               rec_q [NUM_OWNERS];
	logic [cfbs_pkg::OWNER_W-1:0] owner_q;
	logic                        owner_ok_q;
	logic [RW-1:0]               rd_q;
	logic [RW-1:0]               wr_q;
	logic [OW-1:0]               p_q;
	logic [BW-1:0]               earliest_q;
	logic [BW-1:0]               own_q;
	logic [BW-1:0]               b_q;
	logic [AW-1:0]               chk_q;
	logic                        pend_q;
	logic [AW-1:0]               chosen_q;
	logic                        found_q;
	logic                        out_valid_q;
	logic [cfbs_pkg::INDEX_W-1:0] batch_index_q;
	logic                        opened_q;
	logic                        overflow_q;

	logic                        owner_ok;
	logic                        pred_bit;
	logic [BW-1:0]               earliest_nxt;
	logic [2*RW-1:0]             union_rdata;
	logic [RW-1:0]               br;
	logic [RW-1:0]               bw;
	logic                        clash;
	logic                        hit;
	logic                        issue;
	logic                        adv;
	logic                        ovf;
	logic [AW-1:0]               chosen;
	logic [BW-1:0]               chosen_next;
	logic                        ram_we;
	logic [2*RW-1:0]             ram_wdata;
	logic                        ram_re;

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign batch_index  = batch_index_q;
	assign opened_batch = opened_q;
	assign overflow     = overflow_q;

	assign owner_ok = ({1'b0, owner_id} < (cfbs_pkg::OWNER_W + 1)'(NUM_OWNERS));

	// Predecessor pass: one owner record compared against the running maximum per cycle.
	assign pred_bit     = pred_q[{owner_q, cfbs_pkg::OWNER_W'(p_q)}];
	assign earliest_nxt = (pred_bit && (rec_q[p_q] > earliest_q)) ? rec_q[p_q] : earliest_q;

	// Conflict check against the union word read in the previous cycle.
	assign br    = union_rdata[RW-1:0];
	assign bw    = union_rdata[2*RW-1:RW];
	assign clash = ((wr_q & (br | bw)) != '0) || ((bw & (rd_q | wr_q)) != '0);
	assign hit   = pend_q && !clash;
	assign issue = !hit && (b_q < used_q);

	assign adv         = !out_valid_q || out_ready;
	assign ovf         = !found_q && (used_q == BW'(MAX_BATCHES));
	assign chosen      = found_q ? chosen_q : used_q[AW-1:0];
	assign chosen_next = BW'(chosen) + BW'(1);

	assign ram_re    = (state_q == S_SCAN) && issue;
	assign ram_we    = (state_q == S_WRITE) && adv && !ovf;
	assign ram_wdata = found_q ? (union_rdata | {wr_q, rd_q}) : {wr_q, rd_q};

	cfbs_ram #(
		.WIDTH(2 * RW),
		.DEPTH(MAX_BATCHES)
	) u_union_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(chosen),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(b_q[AW-1:0]),
		.rdata(union_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pred_q      <= '0;
			used_q      <= '0;
			for (int i = 0; i < NUM_OWNERS; i++) begin
				rec_q[i] <= '0;
			end
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pred_q <= cfg_data;
			end
			// In S_WRITE the output register is refilled below instead.
			if (out_valid_q && out_ready && (state_q != S_WRITE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						owner_q    <= owner_id;
						owner_ok_q <= owner_ok;
						rd_q       <= job_read_mask[RW-1:0];
						wr_q       <= job_write_mask[RW-1:0];
						p_q        <= '0;
						earliest_q <= '0;
						own_q      <= '0;
						b_q        <= '0;
						pend_q     <= 1'b0;
						found_q    <= 1'b0;
						if (first_of_tick) begin
							used_q <= '0;
							for (int i = 0; i < NUM_OWNERS; i++) begin
								rec_q[i] <= '0;
							end
						end
						state_q <= owner_ok ? S_PRED : S_SCAN;
					end
				end
				S_PRED: begin
					earliest_q <= earliest_nxt;
					if (cfbs_pkg::OWNER_W'(p_q) == owner_q) begin
						own_q <= rec_q[p_q];
					end
					if (p_q == OW'(NUM_OWNERS - 1)) begin
						b_q     <= earliest_nxt;
						state_q <= S_SCAN;
					end else begin
						p_q <= p_q + OW'(1);
					end
				end
				S_SCAN: begin
					if (hit) begin
						chosen_q <= chk_q;
						found_q  <= 1'b1;
						pend_q   <= 1'b0;
						state_q  <= S_WRITE;
					end else if (issue) begin
						chk_q  <= b_q[AW-1:0];
						b_q    <= b_q + BW'(1);
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (adv) begin
						out_valid_q <= 1'b1;
						if (ovf) begin
							batch_index_q <= '0;
							opened_q      <= 1'b0;
							overflow_q    <= 1'b1;
						end else begin
							batch_index_q <= cfbs_pkg::INDEX_W'(chosen);
							opened_q      <= !found_q;
							overflow_q    <= 1'b0;
							if (!found_q) begin
								used_q <= used_q + BW'(1);
							end
							if (owner_ok_q && (own_q < chosen_next)) begin
								rec_q[owner_q[OW-1:0]] <= chosen_next;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The batch count never passes the number of batch slots.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= BW'(MAX_BATCHES))
		else $error("batch count exceeds the number of batch slots");

	// A request that starts a new tick sees an empty batch set.
	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && first_of_tick) |=> (used_q == '0))
		else $error("batch count not cleared at the start of a tick");

	// Opening a batch bumps the batch count by exactly one.
	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && adv && !found_q && !ovf) |=>
		(used_q == $past(used_q) + BW'(1)))
		else $error("opened batch did not advance the batch count");

	// A pending compare always refers to an open batch.
	a_pend_open: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (BW'(chk_q) < used_q))
		else $error("scan compared a batch that is not open");

	// An overflow result never claims a batch.
	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (!opened_batch && (batch_index == '0)))
		else $error("overflow result carries a batch");

endmodule
